/* hdl/slipdf_pkg.sv */
package slipdf_pkg;

	// SLIP special characters
	localparam logic [7:0] BYTE_END     = 8'hC0;
	localparam logic [7:0] BYTE_ESC     = 8'hDB;
	localparam logic [7:0] BYTE_ESC_END = 8'hDC;
	localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

	// IPv4 header positions and checks
	localparam logic [15:0] MIN_HEADER_LEN = 16'd20;
	localparam logic [15:0] PROTO_POS      = 16'd9;
	localparam logic [15:0] DEST_POS       = 16'd16;
	localparam logic [15:0] DEST_POS_END   = 16'd19;
	localparam logic [3:0]  IPV4_VERSION   = 4'd4;

	// configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_LEN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WANTED_PROTOCOL = 1'd1;
	localparam logic [15:0] MAX_PACKET_LEN_RST  = 16'd1600;
	localparam logic [7:0]  WANTED_PROTOCOL_RST = 8'd6;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_DROP   = 2'd2;
	localparam logic [1:0] KIND_OVF    = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic [31:0] dest_address;
		logic        last;
	} result_t;

endpackage

/* hdl/slipdf_ifs.sv */
// raw byte channel
interface slipdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// decoded result channel
interface slipdf_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic [31:0] dest_address;
	logic        last;
	modport source (output valid, output kind, output data_byte, output byte_index,
		output frame_length, output dest_address, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input frame_length, input dest_address, input last, output ready);
endinterface

// register write channel
interface slipdf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [slipdf_pkg::CFG_IDX_W-1:0]   index;
	logic [slipdf_pkg::CFG_DAT_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/slip_deframer_ipv4_tcp_filter.sv */
// Channel   Dir  Beat contents
// rx_in     in   rx_byte: one raw serial byte
// res_out   out  kind, data_byte, byte_index, frame_length, dest_address, last
// cfg       in   index, data: register write (0 max_packet_len, 1 wanted_protocol)
//
// One byte is taken per cycle while ready is high; it is registered in the input stage and decoded
// from the input register against the frame state, into a two-entry result queue.
// A byte that causes two results (data then overflow) waits for the queue to empty; in a
// steady stream it leaves a bubble before its two beats, others go through one per cycle.
// Reset clears frame state, queue and input stage, and loads register defaults.
// A stalled output fills the queue and then holds the input stage, which drops ready.
module slip_deframer_ipv4_tcp_filter (
	input logic           clk,
	input logic           arst_n,
	slipdf_byte_if.sink   rx_in,
	slipdf_res_if.source  res_out,
	slipdf_cfg_if.sink    cfg
);

	// configuration registers
	logic [15:0] max_len_q;
	logic [7:0]  want_proto_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	logic        esc_q;
	logic [15:0] cnt_q;
	logic [3:0]  ver_q;
	logic [7:0]  proto_q;
	logic [31:0] dest_q;

	// result queue
	slipdf_pkg::result_t r0_q, r1_q;
	logic [1:0] rcnt_q;

	// decode outputs
	logic        esc_d;
	logic [15:0] cnt_d;
	logic [3:0]  ver_d;
	logic [7:0]  proto_d;
	logic [31:0] dest_d;
	logic [1:0]  n_new;
	slipdf_pkg::result_t new0, new1;
	logic        do_store;
	logic [7:0]  st_byte;
	logic [15:0] cnt_inc;
	logic        frame_ok;

	logic s1_fire;
	logic in_ready;
	logic pop;
	logic [1:0] rcnt_pop;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= slipdf_pkg::MAX_PACKET_LEN_RST;
			want_proto_q <= slipdf_pkg::WANTED_PROTOCOL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				slipdf_pkg::REG_MAX_PACKET_LEN:  max_len_q <= cfg.data;
				slipdf_pkg::REG_WANTED_PROTOCOL: want_proto_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// byte decode, frame counting and header capture
	always_comb begin
		esc_d    = esc_q;
		cnt_d    = cnt_q;
		ver_d    = ver_q;
		proto_d  = proto_q;
		dest_d   = dest_q;
		n_new    = 2'd0;
		new0     = '0;
		new1     = '0;
		do_store = 1'b0;
		st_byte  = byte_s1;
		cnt_inc  = cnt_q + 16'd1;
		frame_ok = (cnt_q >= slipdf_pkg::MIN_HEADER_LEN) && (ver_q == slipdf_pkg::IPV4_VERSION)
			&& (proto_q == want_proto_q);

		if (esc_q) begin
			esc_d = 1'b0;
			if (byte_s1 == slipdf_pkg::BYTE_ESC_END) begin
				do_store = 1'b1;
				st_byte  = slipdf_pkg::BYTE_END;
			end else if (byte_s1 == slipdf_pkg::BYTE_ESC_ESC) begin
				do_store = 1'b1;
				st_byte  = slipdf_pkg::BYTE_ESC;
			end
		end else if (byte_s1 == slipdf_pkg::BYTE_END) begin
			// empty frame gives nothing
			if (cnt_q != 16'd0) begin
				n_new             = 2'd1;
				cnt_d             = 16'd0;
				new0.kind         = frame_ok ? slipdf_pkg::KIND_ACCEPT : slipdf_pkg::KIND_DROP;
				new0.frame_length = cnt_q;
				new0.dest_address = frame_ok ? dest_q : 32'd0;
				new0.last         = 1'b1;
			end
		end else if (byte_s1 == slipdf_pkg::BYTE_ESC) begin
			esc_d = 1'b1;
		end else begin
			do_store = 1'b1;
		end

		if (do_store) begin
			if (cnt_q == 16'd0)
				ver_d = st_byte[7:4];
			if (cnt_q == slipdf_pkg::PROTO_POS)
				proto_d = st_byte;
			if (cnt_q >= slipdf_pkg::DEST_POS && cnt_q <= slipdf_pkg::DEST_POS_END)
				dest_d = {dest_q[23:0], st_byte};
			new0.kind       = slipdf_pkg::KIND_DATA;
			new0.data_byte  = st_byte;
			new0.byte_index = cnt_q;
			// overflow: count restarts, overflow result follows the data beat
			if (cnt_inc >= max_len_q) begin
				n_new     = 2'd2;
				cnt_d     = 16'd0;
				new0.last = 1'b0;
				new1.kind = slipdf_pkg::KIND_OVF;
				new1.last = 1'b1;
			end else begin
				n_new     = 2'd1;
				cnt_d     = cnt_inc;
				new0.last = 1'b1;
			end
		end
	end

	// handshake control
	assign s1_fire  = valid_s1 && ({1'b0, n_new} <= (3'd2 - {1'b0, rcnt_q}));
	assign in_ready = !valid_s1 || s1_fire;
	assign rx_in.ready = in_ready;
	assign pop      = res_out.valid && res_out.ready;
	assign rcnt_pop = rcnt_q - {1'b0, pop};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= rx_in.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && rx_in.valid)
			byte_s1 <= rx_in.rx_byte;
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			cnt_q   <= 16'd0;
			ver_q   <= 4'd0;
			proto_q <= 8'd0;
			dest_q  <= 32'd0;
		end else if (s1_fire) begin
			esc_q   <= esc_d;
			cnt_q   <= cnt_d;
			ver_q   <= ver_d;
			proto_q <= proto_d;
			dest_q  <= dest_d;
		end
	end

	// result queue: pop shifts, new results append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rcnt_q <= 2'd0;
		else
			rcnt_q <= rcnt_pop + (s1_fire ? n_new : 2'd0);
	end

	always_ff @(posedge clk) begin
		if (pop)
			r0_q <= r1_q;
		if (s1_fire && n_new != 2'd0) begin
			if (rcnt_pop == 2'd0) begin
				r0_q <= new0;
				r1_q <= new1;
			end else begin
				r1_q <= new0;
			end
		end
	end

	assign res_out.valid        = (rcnt_q != 2'd0);
	assign res_out.kind         = r0_q.kind;
	assign res_out.data_byte    = r0_q.data_byte;
	assign res_out.byte_index   = r0_q.byte_index;
	assign res_out.frame_length = r0_q.frame_length;
	assign res_out.dest_address = r0_q.dest_address;
	assign res_out.last         = r0_q.last;

	// queue never overfills
	a_rcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q != 2'd3)
		else $error("result queue overfilled");

	// a byte with two results only enters an empty queue
	a_pair_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && n_new == 2'd2) |-> rcnt_q == 2'd0)
		else $error("result pair pushed into busy queue");

	// a non-final data beat is followed by the overflow beat
	a_ovf_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q == 2'd2 && r0_q.kind == slipdf_pkg::KIND_DATA && !r0_q.last)
			|-> r1_q.kind == slipdf_pkg::KIND_OVF)
		else $error("overflow beat missing after data beat");

	// overflow beats always close their byte
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.kind == slipdf_pkg::KIND_OVF) |-> res_out.last)
		else $error("overflow beat without last");

endmodule
